// ===== sv/b64e_pkg.sv =====
// Shared types, constants and the alphabet lookup for the line-wrapped base64 encoder.
package b64e_pkg;

    localparam logic       OP_DATA     = 1'b0;
    localparam logic       OP_FLUSH    = 1'b1;
    localparam logic [7:0] WRAP_RESET  = 8'd73;
    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic [7:0] NL_CHAR     = 8'h0A;
    localparam int         QUEUE_DEPTH = 4;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } out_item_t;

    // One encoding group as handed from the front end to the back end.
    typedef struct packed {
        logic        nl;
        logic [23:0] grp;
        logic [2:0]  data_chars;
    } b64e_job_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        c = 8'h2F;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end
        return c;
    endfunction

endpackage

// ===== sv/base64_line_wrapped_encoder_core.sv =====
// Top level of the line-wrapped base64 encoder: config register, front end, queue, back end.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------
//  input    | push / full          | item   (opcode, data_byte)
//  result   | pop / empty          | result (out_char, last)
//  config   | cfg_valid/cfg_ready  | cfg_data (wrap column, 8 bits)
//
// An input item is taken whenever the group queue has room.
// A complete group leaves as four or five characters at one per cycle while the result
// side keeps popping, so the back end's output register sets the sustained rate; a
// padded flush group also leaves as four or five characters.
// Reset is asynchronous; the wrap column returns to 73. The queue memory is not cleared.
// A stalled result side fills the QDEPTH-entry group queue before full rises.
module base64_line_wrapped_encoder_core #(
    parameter int QDEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  b64e_pkg::in_item_t  item,
    output logic                empty,
    input  logic                pop,
    output b64e_pkg::out_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);
    import b64e_pkg::*;

    logic       [7:0] wrap_col_reg, wrap_col_next;
    logic             accept;
    logic             job_push;
    b64e_job_t        job_in;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    b64e_job_t        job_out;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign accept    = push && !q_full;

    always_comb
    begin
        wrap_col_next = wrap_col_reg;
        if (cfg_valid && cfg_ready)
        begin
            wrap_col_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_col_reg <= WRAP_RESET;
        end
        else
        begin
            wrap_col_reg <= wrap_col_next;
        end
    end

    b64e_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .wrap_column (wrap_col_reg),
        .job_valid   (job_push),
        .job         (job_in)
    );

    b64e_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (job_out),
        .empty   (q_empty)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (!q_empty),
        .job       (job_out),
        .job_take  (q_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

`ifndef SYNTH
    // A group is only formed when the queue has room for it.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !q_full)
        else $error("group written into a full queue");

    // The back end only takes a group that is present.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("group taken from an empty queue");

    // A newline is only ever emitted ahead of a group, so it never closes a transaction.
    a_nl_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.out_char == NL_CHAR) |-> !result.last)
        else $error("newline flagged as last character");
`endif

endmodule

// ===== sv/b64e_front.sv =====
// Front end: accepts bytes and flushes, holds pending bytes and the column, forms groups.
module b64e_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  b64e_pkg::in_item_t item,
    input  logic [7:0]        wrap_column,
    output logic              job_valid,
    output b64e_pkg::b64e_job_t job
);
    import b64e_pkg::*;

    logic [15:0] pend_bits_reg, pend_bits_next;
    logic [1:0]  pend_cnt_reg, pend_cnt_next;
    logic [7:0]  column_reg, column_next;
    logic        wrap;
    logic [7:0]  base_col;
    logic [8:0]  col_sum;

    always_comb
    begin
        wrap           = (column_reg >= wrap_column);
        base_col       = wrap ? 8'd0 : column_reg;
        col_sum        = {1'b0, base_col} + 9'd4;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        column_next    = column_reg;
        job_valid      = 1'b0;
        job.nl         = wrap;
        job.grp        = {pend_bits_reg, item.data_byte};
        job.data_chars = 3'd4;
        if (accept)
        begin
            if (item.opcode == OP_DATA)
            begin
                if (pend_cnt_reg < 2'd2)
                begin
                    pend_bits_next = {pend_bits_reg[7:0], item.data_byte};
                    pend_cnt_next  = pend_cnt_reg + 2'd1;
                end
                else
                begin
                    job_valid      = 1'b1;
                    column_next    = col_sum[8] ? 8'd255 : col_sum[7:0];
                    pend_bits_next = '0;
                    pend_cnt_next  = '0;
                end
            end
            else
            begin
                if (pend_cnt_reg != 2'd0)
                begin
                    job_valid      = 1'b1;
                    job.grp        = (pend_cnt_reg == 2'd1) ? {pend_bits_reg[7:0], 16'h0000}
                                                            : {pend_bits_reg, 8'h00};
                    job.data_chars = {1'b0, pend_cnt_reg} + 3'd1;
                end
                pend_bits_next = '0;
                pend_cnt_next  = '0;
                column_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            column_reg    <= '0;
        end
        else
        begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            column_reg    <= column_next;
        end
    end

endmodule

// ===== sv/b64e_queue.sv =====
// Short group queue between the front end and the character back end.
module b64e_queue #(
    parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  b64e_pkg::b64e_job_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output b64e_pkg::b64e_job_t rd_data,
    output logic                empty
);
    import b64e_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64e_job_t       mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/b64e_back.sv =====
// Back end: turns one queued group into an optional newline and four characters, one per cycle while popped.
module b64e_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_avail,
    input  b64e_pkg::b64e_job_t job,
    output logic                job_take,
    output logic                empty,
    input  logic                pop,
    output b64e_pkg::out_item_t result
);
    import b64e_pkg::*;

    logic        busy_reg, busy_next;
    logic        nl_reg, nl_next;
    logic [23:0] grp_reg, grp_next;
    logic [2:0]  dleft_reg, dleft_next;
    logic [2:0]  left_reg, left_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   result_reg, result_next;
    out_item_t   emit;
    logic        advance;
    logic        finishing;

    assign empty  = !out_valid_reg;
    assign result = result_reg;

    always_comb
    begin
        advance   = busy_reg && (!out_valid_reg || pop);
        finishing = advance && !nl_reg && (left_reg == 3'd1);
        job_take  = job_avail && (!busy_reg || finishing);

        if (nl_reg)
        begin
            emit.out_char = NL_CHAR;
        end
        else if (dleft_reg != 3'd0)
        begin
            emit.out_char = b64_char(grp_reg[23:18]);
        end
        else
        begin
            emit.out_char = PAD_CHAR;
        end
        emit.last = !nl_reg && (left_reg == 3'd1);

        busy_next      = busy_reg;
        nl_next        = nl_reg;
        grp_next       = grp_reg;
        dleft_next     = dleft_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;

        if (advance)
        begin
            out_valid_next = 1'b1;
            result_next    = emit;
            if (nl_reg)
            begin
                nl_next = 1'b0;
            end
            else
            begin
                grp_next  = {grp_reg[17:0], 6'd0};
                left_next = left_reg - 3'd1;
                if (dleft_reg != 3'd0)
                begin
                    dleft_next = dleft_reg - 3'd1;
                end
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        if (finishing)
        begin
            busy_next = 1'b0;
        end
        if (job_take)
        begin
            busy_next  = 1'b1;
            nl_next    = job.nl;
            grp_next   = job.grp;
            dleft_next = job.data_chars;
            left_next  = 3'd4;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg    <= grp_next;
        dleft_reg  <= dleft_next;
        left_reg   <= left_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            nl_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            nl_reg        <= nl_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
